>>> rtl/core/spp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence-to-phase phasor package
// Widths, fixed-point constants, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Number of CORDIC iterations in each chain.
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int SHIFT_W       = $clog2(MAX_STAGES);

  // Field widths.
  localparam int MAG_W  = 24;
  localparam int ANG_W  = 16;
  localparam int PMAG_W = 26;

  // Internal widths: rectangular values, CORDIC angle, scaled magnitude.
  localparam int DW   = 38;
  localparam int ZW   = 32;
  localparam int X0_W = 32;
  localparam int VXU_W = 36;
  localparam int HALF_W = VXU_W / 2;

  // Lanes: zero sequence, positive per phase, negative per phase.
  localparam int PHASES    = 3;
  localparam int ROT_LANES = 1 + 2 * PHASES;
  localparam int LANE_ZERO = 0;
  localparam int LANE_POS  = 1;
  localparam int LANE_NEG  = 1 + PHASES;

  // Front stages, back stages and overall latency.
  localparam int FRONT_LAT = 3;
  localparam int BACK_LAT  = 2;
  localparam int LAT       = FRONT_LAT + CORDIC_STAGES + 2 + CORDIC_STAGES + BACK_LAT;

  // Fixed-point constants.
  localparam logic [23:0] INV_K     = 24'd10188014;
  localparam logic [23:0] INV_SQRT3 = 24'd9686330;
  localparam logic [23:0] RECIP3    = 24'd11184811;
  localparam logic [PMAG_W-1:0] MAG_MAX = 26'd50331645;

  // Angles in 1/64 degree.
  localparam int DEG30     = 1920;
  localparam int DEG90     = 5760;
  localparam int DEG120    = 7680;
  localparam int DEG180    = 11520;
  localparam int DEG270    = 17280;
  localparam int FULL_TURN = 23040;

  // Flags of a phase sum that the angle rule needs.
  typedef struct packed {
    logic xz;
    logic yz;
    logic xneg;
    logic ypos;
  } side_t;

  // Arctangent of 2^-i in units of 2^-20 degree.
  function automatic logic signed [ZW-1:0] atan_val(input logic [SHIFT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/spp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence phasor channel
// Valid/ready channel carrying one word of sequence phasors.
// ----------------------------------------------------------------------------
interface spp_in_if;
  import spp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MAG_W-1:0]        pos_mag;
  logic signed [ANG_W-1:0] pos_ang;
  logic [MAG_W-1:0]        neg_mag;
  logic signed [ANG_W-1:0] neg_ang;
  logic [MAG_W-1:0]        zero_mag;
  logic signed [ANG_W-1:0] zero_ang;

  modport source (output valid, pos_mag, pos_ang, neg_mag, neg_ang, zero_mag, zero_ang,
                  input ready);
  modport sink (input valid, pos_mag, pos_ang, neg_mag, neg_ang, zero_mag, zero_ang,
                output ready);
endinterface

>>> rtl/core/spp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase phasor channel
// Valid/ready channel carrying one word of phase magnitudes and angles.
// ----------------------------------------------------------------------------
interface spp_out_if;
  import spp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PMAG_W-1:0]       phase_a_mag;
  logic signed [ANG_W-1:0] phase_a_ang;
  logic [PMAG_W-1:0]       phase_b_mag;
  logic signed [ANG_W-1:0] phase_b_ang;
  logic [PMAG_W-1:0]       phase_c_mag;
  logic signed [ANG_W-1:0] phase_c_ang;

  modport source (output valid, phase_a_mag, phase_a_ang, phase_b_mag, phase_b_ang,
                  phase_c_mag, phase_c_ang, input ready);
  modport sink (input valid, phase_a_mag, phase_a_ang, phase_b_mag, phase_b_ang,
                phase_c_mag, phase_c_ang, output ready);
endinterface

>>> rtl/core/spp_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One registered micro-rotation of one lane, driving the residual angle to 0.
// ----------------------------------------------------------------------------
module spp_rot_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [spp_pkg::SHIFT_W-1:0]      shift,
  input  logic signed [spp_pkg::DW-1:0]    x_in,
  input  logic signed [spp_pkg::DW-1:0]    y_in,
  input  logic signed [spp_pkg::ZW-1:0]    z_in,
  input  logic                             flip_in,
  output logic signed [spp_pkg::DW-1:0]    x_out,
  output logic signed [spp_pkg::DW-1:0]    y_out,
  output logic signed [spp_pkg::ZW-1:0]    z_out,
  output logic                             flip_out
);
  import spp_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] at;

  // Shifted cross terms and the step angle for this iteration.
  assign dx = y_in >>> shift;
  assign dy = x_in >>> shift;
  assign at = atan_val(shift);

  // Rotate towards a zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end
      flip_out <= flip_in;
    end
  end

endmodule

>>> rtl/core/spp_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One registered micro-rotation of one phase, driving the imaginary part to 0.
// ----------------------------------------------------------------------------
module spp_vec_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [spp_pkg::SHIFT_W-1:0]      shift,
  input  logic signed [spp_pkg::DW-1:0]    x_in,
  input  logic signed [spp_pkg::DW-1:0]    y_in,
  input  logic signed [spp_pkg::ZW-1:0]    z_in,
  input  spp_pkg::side_t                   side_in,
  output logic signed [spp_pkg::DW-1:0]    x_out,
  output logic signed [spp_pkg::DW-1:0]    y_out,
  output logic signed [spp_pkg::ZW-1:0]    z_out,
  output spp_pkg::side_t                   side_out
);
  import spp_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] at;

  // Shifted cross terms and the step angle for this iteration.
  assign dx = y_in >>> shift;
  assign dy = x_in >>> shift;
  assign at = atan_val(shift);

  // Rotate the vector onto the real axis, accumulating the angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[DW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end
      side_out <= side_in;
    end
  end

endmodule

>>> rtl/core/spp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input conditioning
// Registers the word, applies line mode, wraps and folds the seven angles and
// removes the CORDIC gain from the three magnitudes.
// ----------------------------------------------------------------------------
module spp_front (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              input_mode,
  input  logic [spp_pkg::MAG_W-1:0]         pos_mag,
  input  logic signed [spp_pkg::ANG_W-1:0]  pos_ang,
  input  logic [spp_pkg::MAG_W-1:0]         neg_mag,
  input  logic signed [spp_pkg::ANG_W-1:0]  neg_ang,
  input  logic [spp_pkg::MAG_W-1:0]         zero_mag,
  input  logic signed [spp_pkg::ANG_W-1:0]  zero_ang,
  output logic [spp_pkg::X0_W-1:0]          pos_x0,
  output logic [spp_pkg::X0_W-1:0]          neg_x0,
  output logic [spp_pkg::X0_W-1:0]          zero_x0,
  output logic signed [spp_pkg::ZW-1:0]     z0 [spp_pkg::ROT_LANES],
  output logic                              flip [spp_pkg::ROT_LANES]
);
  import spp_pkg::*;

  // First stage: the word as accepted.
  logic [MAG_W-1:0]        pm1, nm1, zm1;
  logic signed [ANG_W-1:0] pa1, na1, za1;

  // Second stage: scaled magnitudes and folded angles.
  logic [MAG_W-1:0]        pm2, nm2, zm2;
  logic signed [ANG_W-1:0] fa2 [ROT_LANES];
  logic                    fl2 [ROT_LANES];

  logic [47:0]             pm_prod;
  logic [48:0]             zm_prod;
  logic [MAG_W-1:0]        pm_s, nm_s, zm_s;
  logic signed [17:0]      pbase, nbase;
  logic signed [17:0]      raw [ROT_LANES];
  logic signed [17:0]      wr [ROT_LANES];
  logic signed [17:0]      fo [ROT_LANES];
  logic                    fl [ROT_LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      pm1 <= pos_mag;
      pa1 <= pos_ang;
      nm1 <= neg_mag;
      na1 <= neg_ang;
      zm1 <= zero_mag;
      za1 <= zero_ang;
    end
  end

  // Line mode: divide by sqrt3 and by three, drop the negative sequence.
  assign pm_prod = 48'(pm1) * 48'(INV_SQRT3) + 48'h800000;
  assign zm_prod = 49'({1'b0, zm1} + 25'd1) * 49'(RECIP3);
  assign pm_s  = input_mode ? pm_prod[47:24] : pm1;
  assign nm_s  = input_mode ? '0 : nm1;
  assign zm_s  = input_mode ? zm_prod[48:25] : zm1;
  assign pbase = 18'(pa1) - (input_mode ? 18'sd1920 : 18'sd0);
  assign nbase = input_mode ? 18'sd0 : 18'(na1);

  // Per-lane angle: offset, wrap into [-180, 180), fold into [-90, 90].
  always_comb begin
    raw[LANE_ZERO] = 18'(za1);
    raw[LANE_POS]     = pbase;
    raw[LANE_POS + 1] = pbase - 18'(DEG120);
    raw[LANE_POS + 2] = pbase + 18'(DEG120);
    raw[LANE_NEG]     = nbase;
    raw[LANE_NEG + 1] = nbase + 18'(DEG120);
    raw[LANE_NEG + 2] = nbase - 18'(DEG120);
    for (int l = 0; l < ROT_LANES; l++) begin
      wr[l] = raw[l];
      if (wr[l] >= 18'sd11520) wr[l] = wr[l] - 18'(FULL_TURN);
      if (wr[l] >= 18'sd11520) wr[l] = wr[l] - 18'(FULL_TURN);
      if (wr[l] < -18'sd11520) wr[l] = wr[l] + 18'(FULL_TURN);
      if (wr[l] < -18'sd11520) wr[l] = wr[l] + 18'(FULL_TURN);
      fo[l] = wr[l];
      fl[l] = 1'b0;
      if (wr[l] > 18'sd5760) begin
        fo[l] = wr[l] - 18'(DEG180);
        fl[l] = 1'b1;
      end else if (wr[l] < -18'sd5760) begin
        fo[l] = wr[l] + 18'(DEG180);
        fl[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm2 <= pm_s;
      nm2 <= nm_s;
      zm2 <= zm_s;
      for (int l = 0; l < ROT_LANES; l++) begin
        fa2[l] <= ANG_W'(fo[l]);
        fl2[l] <= fl[l];
      end
    end
  end

  // Third stage: gain compensation and CORDIC angle units.
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x0  <= X0_W'((48'(pm2) * 48'(INV_K) + 48'd32768) >> 16);
      neg_x0  <= X0_W'((48'(nm2) * 48'(INV_K) + 48'd32768) >> 16);
      zero_x0 <= X0_W'((48'(zm2) * 48'(INV_K) + 48'd32768) >> 16);
      for (int l = 0; l < ROT_LANES; l++) begin
        z0[l]   <= ZW'(fa2[l]) <<< 14;
        flip[l] <= fl2[l];
      end
    end
  end

endmodule

>>> rtl/core/spp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar output stage
// Removes the CORDIC gain from one phase magnitude and applies the angle rule.
// ----------------------------------------------------------------------------
module spp_back (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [spp_pkg::DW-1:0]     vx,
  input  logic signed [spp_pkg::ZW-1:0]     z,
  input  spp_pkg::side_t                    side,
  output logic [spp_pkg::PMAG_W-1:0]        mag,
  output logic signed [spp_pkg::ANG_W-1:0]  ang
);
  import spp_pkg::*;

  logic [VXU_W-1:0]          vxc;
  logic signed [ZW-1:0]      off;
  logic signed [ZW-1:0]      zr;
  logic signed [ZW-1:0]      zc;
  logic signed [ANG_W-1:0]   ang_sel;
  logic [HALF_W+23:0]        p_lo, p_hi;
  logic signed [ANG_W-1:0]   ang1;
  logic [60:0]               full;
  logic [28:0]               m;

  // A negative result magnitude clamps to zero.
  assign vxc = vx[DW-1] ? '0 : vx[VXU_W-1:0];

  // Half-turn offset for vectors in the left half plane, then rounding.
  assign off = !side.xneg ? '0 : (side.ypos ? ZW'(DEG180 * 16384) : -ZW'(DEG180 * 16384));
  assign zr  = (off + z + ZW'(8192)) >>> 14;
  assign zc  = (zr > ZW'(DEG180)) ? ZW'(DEG180) :
               (zr < -ZW'(DEG180)) ? -ZW'(DEG180) : zr;

  // Exact axis cases override the CORDIC angle.
  always_comb begin
    if (side.xz) begin
      if (side.yz) ang_sel = '0;
      else if (side.ypos) ang_sel = ANG_W'(DEG90);
      else ang_sel = ANG_W'(DEG270);
    end else if (side.yz) begin
      ang_sel = side.xneg ? ANG_W'(DEG180) : '0;
    end else begin
      ang_sel = ANG_W'(zc);
    end
  end

  // First stage: split gain product.
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= (HALF_W + 24)'(vxc[HALF_W-1:0]) * (HALF_W + 24)'(INV_K);
      p_hi <= (HALF_W + 24)'(vxc[VXU_W-1:HALF_W]) * (HALF_W + 24)'(INV_K);
      ang1 <= ang_sel;
    end
  end

  // Second stage: join, round, saturate.
  assign full = (61'(p_hi) << HALF_W) + 61'(p_lo) + 61'h80000000;
  assign m    = full[60:32];

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= (m > 29'(MAG_MAX)) ? MAG_MAX : m[PMAG_W-1:0];
      ang <= ang1;
    end
  end

endmodule

>>> rtl/core/sequence_to_phase_phasors_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence-to-phase phasors, top level
// Throughput: one word per cycle; the pipeline holds only when a result waits.
// The rate is set by the two chains of CORDIC cells, one iteration per cell.
// Reset clears the valid pipeline and sets input_mode to sequence components.
// ----------------------------------------------------------------------------
module sequence_to_phase_phasors_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  spp_in_if.sink     seq_in,
  spp_out_if.source  phase_out
);
  import spp_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic              input_mode;
  logic              en;
  logic [LAT-1:0]    vld;

  logic [X0_W-1:0]   pos_x0, neg_x0, zero_x0;
  logic signed [ZW-1:0] z0 [ROT_LANES];
  logic              fl0 [ROT_LANES];

  logic signed [DW-1:0] rx [N+1][ROT_LANES];
  logic signed [DW-1:0] ry [N+1][ROT_LANES];
  logic signed [ZW-1:0] rz [N+1][ROT_LANES];
  logic                 rf [N+1][ROT_LANES];

  logic signed [DW-1:0] sx [PHASES];
  logic signed [DW-1:0] sy [PHASES];

  logic signed [DW-1:0] vx [N+1][PHASES];
  logic signed [DW-1:0] vy [N+1][PHASES];
  logic signed [ZW-1:0] vz [N+1][PHASES];
  side_t                vs [N+1][PHASES];

  logic [PMAG_W-1:0]       mag [PHASES];
  logic signed [ANG_W-1:0] ang [PHASES];

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      input_mode <= cfg_wr_data;
    end
  end

  // The whole pipeline advances unless a finished word is held.
  assign en           = !vld[LAT-1] || phase_out.ready;
  assign seq_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], seq_in.valid};
    end
  end

  spp_front u_front (
    .clk       (clk),
    .en        (en),
    .input_mode(input_mode),
    .pos_mag   (seq_in.pos_mag),
    .pos_ang   (seq_in.pos_ang),
    .neg_mag   (seq_in.neg_mag),
    .neg_ang   (seq_in.neg_ang),
    .zero_mag  (seq_in.zero_mag),
    .zero_ang  (seq_in.zero_ang),
    .pos_x0    (pos_x0),
    .neg_x0    (neg_x0),
    .zero_x0   (zero_x0),
    .z0        (z0),
    .flip      (fl0)
  );

  // Rotation chains, one lane per phasor and phase.
  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      if (l == LANE_ZERO) rx[0][l] = DW'(zero_x0);
      else if (l < LANE_NEG) rx[0][l] = DW'(pos_x0);
      else rx[0][l] = DW'(neg_x0);
      ry[0][l] = '0;
      rz[0][l] = z0[l];
      rf[0][l] = fl0[l];
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_rot
    for (genvar l = 0; l < ROT_LANES; l++) begin : g_lane
      spp_rot_cell u_cell (
        .clk     (clk),
        .en      (en),
        .shift   (SHIFT_W'(s)),
        .x_in    (rx[s][l]),
        .y_in    (ry[s][l]),
        .z_in    (rz[s][l]),
        .flip_in (rf[s][l]),
        .x_out   (rx[s+1][l]),
        .y_out   (ry[s+1][l]),
        .z_out   (rz[s+1][l]),
        .flip_out(rf[s+1][l])
      );
    end
  end

  // Phase sums with the half-turn fold undone.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < PHASES; p++) begin
        sx[p] <= (rf[N][LANE_ZERO] ? -rx[N][LANE_ZERO] : rx[N][LANE_ZERO])
               + (rf[N][LANE_POS+p] ? -rx[N][LANE_POS+p] : rx[N][LANE_POS+p])
               + (rf[N][LANE_NEG+p] ? -rx[N][LANE_NEG+p] : rx[N][LANE_NEG+p]);
        sy[p] <= (rf[N][LANE_ZERO] ? -ry[N][LANE_ZERO] : ry[N][LANE_ZERO])
               + (rf[N][LANE_POS+p] ? -ry[N][LANE_POS+p] : ry[N][LANE_POS+p])
               + (rf[N][LANE_NEG+p] ? -ry[N][LANE_NEG+p] : ry[N][LANE_NEG+p]);
      end
    end
  end

  // Bring each sum into the right half plane and note the axis cases.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < PHASES; p++) begin
        vx[0][p]      <= sx[p][DW-1] ? -sx[p] : sx[p];
        vy[0][p]      <= sx[p][DW-1] ? -sy[p] : sy[p];
        vz[0][p]      <= '0;
        vs[0][p].xz   <= (sx[p] == '0);
        vs[0][p].yz   <= (sy[p] == '0);
        vs[0][p].xneg <= sx[p][DW-1];
        vs[0][p].ypos <= !sy[p][DW-1] && (sy[p] != '0);
      end
    end
  end

  // Vectoring chains and output stages, one per phase.
  for (genvar p = 0; p < PHASES; p++) begin : g_phase
    for (genvar s = 0; s < N; s++) begin : g_vec
      spp_vec_cell u_cell (
        .clk     (clk),
        .en      (en),
        .shift   (SHIFT_W'(s)),
        .x_in    (vx[s][p]),
        .y_in    (vy[s][p]),
        .z_in    (vz[s][p]),
        .side_in (vs[s][p]),
        .x_out   (vx[s+1][p]),
        .y_out   (vy[s+1][p]),
        .z_out   (vz[s+1][p]),
        .side_out(vs[s+1][p])
      );
    end

    spp_back u_back (
      .clk (clk),
      .en  (en),
      .vx  (vx[N][p]),
      .z   (vz[N][p]),
      .side(vs[N][p]),
      .mag (mag[p]),
      .ang (ang[p])
    );
  end

  // Output word.
  assign phase_out.valid       = vld[LAT-1];
  assign phase_out.phase_a_mag = mag[0];
  assign phase_out.phase_a_ang = ang[0];
  assign phase_out.phase_b_mag = mag[1];
  assign phase_out.phase_b_ang = ang[1];
  assign phase_out.phase_c_mag = mag[2];
  assign phase_out.phase_c_ang = ang[2];

endmodule

>>> rtl/core/spp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence-to-phase phasors port checker
// Checks the top level's handshakes and result ranges over time.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spp_pkg::PMAG_W-1:0]        a_mag,
  input logic signed [spp_pkg::ANG_W-1:0]  a_ang,
  input logic [spp_pkg::PMAG_W-1:0]        b_mag,
  input logic signed [spp_pkg::ANG_W-1:0]  b_ang,
  input logic [spp_pkg::PMAG_W-1:0]        c_mag,
  input logic signed [spp_pkg::ANG_W-1:0]  c_ang
);
  import spp_pkg::*;

  // A held result word stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A held result word keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(a_mag) && $stable(a_ang) && $stable(b_mag)
      && $stable(b_ang) && $stable(c_mag) && $stable(c_ang))
    else $error("result word changed while stalled");

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // Input is taken exactly when the output side can move.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output backpressure");

  // Angles stay within the atan2 range or the axis cases.
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> a_ang >= -16'sd11520 && a_ang <= 16'sd17280
      && b_ang >= -16'sd11520 && b_ang <= 16'sd17280
      && c_ang >= -16'sd11520 && c_ang <= 16'sd17280)
    else $error("phase angle out of range");

endmodule

bind sequence_to_phase_phasors_top spp_checker u_spp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (seq_in.ready),
  .out_valid(phase_out.valid),
  .out_ready(phase_out.ready),
  .a_mag    (phase_out.phase_a_mag),
  .a_ang    (phase_out.phase_a_ang),
  .b_mag    (phase_out.phase_b_mag),
  .b_ang    (phase_out.phase_b_ang),
  .c_mag    (phase_out.phase_c_mag),
  .c_ang    (phase_out.phase_c_ang)
);
